// ----- sv/hmsct_pkg.sv -----
`timescale 1ns / 1ps

package hmsct_pkg;

    // Command codes carried on the input channel
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_SELECT = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    localparam logic [5:0]  SECS_MAX     = 6'd59;
    localparam logic [5:0]  MINS_MAX     = 6'd59;
    localparam logic [2:0]  PRESET_COUNT = 3'd5;
    localparam logic [15:0] PERIOD_RESET = 16'd999;

    typedef struct packed {
        logic [15:0] prescale;
        logic [3:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [2:0]  preset_idx;
        logic        counting;
    } t_timer_state;

    typedef struct packed {
        logic [3:0] hour_digit;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
        logic       is_running;
        logic       expired;
        logic       display_update;
    } t_result;

    function automatic logic [3:0] preset_hours(input logic [2:0] idx);
        logic [3:0] h;
        unique case (idx)
            3'd0:    h = 4'd2;
            3'd1:    h = 4'd0;
            3'd2:    h = 4'd1;
            3'd3:    h = 4'd1;
            3'd4:    h = 4'd2;
            default: h = 4'd0;
        endcase
        return h;
    endfunction

    function automatic logic [5:0] preset_minutes(input logic [2:0] idx);
        logic [5:0] m;
        unique case (idx)
            3'd0:    m = 6'd30;
            3'd1:    m = 6'd30;
            3'd2:    m = 6'd0;
            3'd3:    m = 6'd30;
            3'd4:    m = 6'd0;
            default: m = 6'd0;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/hmsct_digits.sv -----
`timescale 1ns / 1ps

// Splits a 0..63 value into tens and ones; tens = (v * 205) >> 11 is exact here.
module hmsct_digits (
    input  logic [5:0] i_value,
    output logic [2:0] o_tens,
    output logic [3:0] o_ones
);
    logic [13:0] prod;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_full;

    assign prod      = {8'd0, i_value} * 14'd205;
    assign o_tens    = prod[13:11];
    assign tens_x10  = {4'd0, o_tens} * 7'd10;
    assign ones_full = {1'b0, i_value} - tens_x10;
    assign o_ones    = ones_full[3:0];
endmodule

// ----- sv/hmsct_step.sv -----
`timescale 1ns / 1ps

// Next-state and flag logic for one beat.
module hmsct_step (
    input  hmsct_pkg::t_timer_state i_state,
    input  logic [1:0]              i_command,
    input  logic                    i_advance,
    input  logic [15:0]             i_period,
    output hmsct_pkg::t_timer_state o_state,
    output logic                    o_expired,
    output logic                    o_update
);
    import hmsct_pkg::*;

    logic [16:0] period_eff;
    logic [16:0] pre_next;
    logic        is_zero;
    logic [2:0]  idx_mod;
    logic [2:0]  idx_sel;
    logic [3:0]  hrs_dec;
    logic [5:0]  min_dec;
    logic [5:0]  sec_dec;
    logic        dec_zero;

    assign period_eff = (i_period == 16'd0) ? 17'd1 : {1'b0, i_period};
    assign pre_next   = {1'b0, i_state.prescale} + 17'd1;
    assign is_zero    = (i_state.hours == 4'd0) && (i_state.minutes == 6'd0)
                      && (i_state.seconds == 6'd0);
    assign idx_mod    = (i_state.preset_idx >= PRESET_COUNT)
                      ? i_state.preset_idx - PRESET_COUNT : i_state.preset_idx;
    assign idx_sel    = !i_advance ? idx_mod
                      : (idx_mod == PRESET_COUNT - 3'd1) ? 3'd0 : idx_mod + 3'd1;

    // Borrow chain for one second off
    always_comb begin
        hrs_dec = i_state.hours;
        min_dec = i_state.minutes;
        sec_dec = i_state.seconds;
        if (i_state.seconds != 6'd0) begin
            sec_dec = i_state.seconds - 6'd1;
        end else if (i_state.minutes != 6'd0) begin
            min_dec = i_state.minutes - 6'd1;
            sec_dec = SECS_MAX;
        end else if (i_state.hours != 4'd0) begin
            hrs_dec = i_state.hours - 4'd1;
            min_dec = MINS_MAX;
            sec_dec = SECS_MAX;
        end
    end
    assign dec_zero = (hrs_dec == 4'd0) && (min_dec == 6'd0) && (sec_dec == 6'd0);

    always_comb begin
        o_state   = i_state;
        o_expired = 1'b0;
        o_update  = 1'b0;
        unique case (i_command)
            CMD_TICK: begin
                if (i_state.counting) begin
                    if (pre_next >= period_eff) begin
                        o_state.prescale = 16'd0;
                        if (is_zero) begin
                            o_state.counting = 1'b0;
                        end else begin
                            o_state.hours   = hrs_dec;
                            o_state.minutes = min_dec;
                            o_state.seconds = sec_dec;
                            o_update        = 1'b1;
                            if (dec_zero) begin
                                o_state.counting = 1'b0;
                                o_expired        = 1'b1;
                            end
                        end
                    end else begin
                        o_state.prescale = pre_next[15:0];
                    end
                end
            end
            CMD_SELECT: begin
                o_state.preset_idx = idx_sel;
                o_state.hours      = preset_hours(idx_sel);
                o_state.minutes    = preset_minutes(idx_sel);
                o_state.seconds    = 6'd0;
                o_state.counting   = 1'b0;
                o_state.prescale   = 16'd0;
                o_update           = 1'b1;
            end
            CMD_START: begin
                if (!is_zero) begin
                    o_state.counting = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end
endmodule

// ----- sv/hms_countdown_timer_presets_core.sv -----
`timescale 1ns / 1ps

// Countdown timer in hours, minutes and seconds with five presets
// (2:30, 0:30, 1:00, 1:30, 2:00). Each input beat is a tick, a preset
// select (i_advance steps to the next preset first) or a start, and
// yields exactly one result beat carrying the display digits, the
// running flag, an expiry flag and a display refresh flag. A tick while
// running advances the prescaler; after i_cfg_wr_data ticks (0 acts as 1)
// one second comes off, borrowing from minutes and hours; at 0:00:00 the
// timer stops and holds. Throughput is one beat per clock while results
// are taken. A beat goes through the input register, then one pass of
// step logic (the single compute stage) into the result register. The
// result register frees itself in the cycle it is taken, so beats stream
// at full rate; while a result waits, one more beat is held in the input
// register and then o_in_ready drops until the result is taken.
// Write the period only while the block is idle.
module hms_countdown_timer_presets_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic        i_advance,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_hour_digit,
    output logic [2:0]  o_minute_tens,
    output logic [3:0]  o_minute_ones,
    output logic [2:0]  o_second_tens,
    output logic [3:0]  o_second_ones,
    output logic        o_is_running,
    output logic        o_expired,
    output logic        o_display_update
);
    import hmsct_pkg::*;

    logic [15:0]  r_period;
    logic         r_in_valid;
    logic [1:0]   r_command;
    logic         r_advance;
    t_timer_state r_state;
    t_timer_state n_state;
    logic         r_out_valid;
    t_result      r_result;
    t_result      n_result;
    logic         step_expired;
    logic         step_update;
    logic         fire;

    // Stage moves when the result register is empty or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    hmsct_step u_step (
        .i_state   (r_state),
        .i_command (r_command),
        .i_advance (r_advance),
        .i_period  (r_period),
        .o_state   (n_state),
        .o_expired (step_expired),
        .o_update  (step_update)
    );

    hmsct_digits u_min_digits (
        .i_value (n_state.minutes),
        .o_tens  (n_result.minute_tens),
        .o_ones  (n_result.minute_ones)
    );

    hmsct_digits u_sec_digits (
        .i_value (n_state.seconds),
        .o_tens  (n_result.second_tens),
        .o_ones  (n_result.second_ones)
    );

    assign n_result.hour_digit     = n_state.hours;
    assign n_result.is_running     = n_state.counting;
    assign n_result.expired        = step_expired;
    assign n_result.display_update = step_update;

    // Control and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_command <= i_command;
            r_advance <= i_advance;
        end
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hour_digit     = r_result.hour_digit;
    assign o_minute_tens    = r_result.minute_tens;
    assign o_minute_ones    = r_result.minute_ones;
    assign o_second_tens    = r_result.second_tens;
    assign o_second_ones    = r_result.second_ones;
    assign o_is_running     = r_result.is_running;
    assign o_expired        = r_result.expired;
    assign o_display_update = r_result.display_update;

    // Timer never runs with zero time left
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.counting |-> ((r_state.hours != 4'd0) || (r_state.minutes != 6'd0)
                              || (r_state.seconds != 6'd0)))
        else $error("counting with zero time");

    // Expiry stops the timer and refreshes the display
    a_expire_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.expired) |-> (!r_result.is_running
                                               && r_result.display_update))
        else $error("expired result still running or not refreshed");

    // A held input beat is not dropped while the output stalls
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("pending beat lost");

    // A stalled result stays put
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_result)))
        else $error("stalled result changed");
endmodule

// ----- test/hms_countdown_timer_presets_core_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the h:mm:ss countdown timer.
// A predictor in this module tracks the timer state and queues one expected
// readout per accepted input beat; the sink side pops and compares each
// output beat in order.
module hms_countdown_timer_presets_core_tb;
    import hmsct_pkg::*;

    // Command value 3 has no meaning; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int STALL_LIMIT    = 1000;  // quiet cycles before the watchdog fires
    localparam int FLUSH_CYCLES   = 4;     // two-stage pipe, plus margin
    localparam int ITEM_TARGET    = 1950;  // the full countdown alone needs ~1860
    localparam int COUNTDOWN_SECS = 1800;  // 0:30:00, the shortest preset

    // Gap styles shared by both sides of the handshake.
    typedef enum logic [1:0] {GAPS_NONE, GAPS_FULL, GAPS_SPARSE} t_gaps;

    // One row of the directed table: a period write, or an input beat that
    // may carry a hand-written expected readout.
    typedef struct packed {
        logic        is_cfg;
        logic [15:0] period;
        logic [1:0]  cmd;
        logic        adv;
        logic        fixed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command = CMD_TICK;
    logic        i_advance = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_hour_digit;
    logic [2:0]  o_minute_tens;
    logic [3:0]  o_minute_ones;
    logic [2:0]  o_second_tens;
    logic [3:0]  o_second_ones;
    logic        o_is_running;
    logic        o_expired;
    logic        o_display_update;

    // Shadow of the timer, advanced once per accepted input beat.
    logic [15:0] pr_period = PERIOD_RESET;
    logic [15:0] pr_prescale = '0;
    logic [3:0]  pr_hours = '0;
    logic [5:0]  pr_mins = '0;
    logic [5:0]  pr_secs = '0;
    logic [2:0]  pr_idx = '0;
    logic        pr_counting = 1'b0;

    t_result     due_readouts[$];     // expected output beats, oldest first
    t_row        dir_rows[$];
    t_gaps       idle_mode = GAPS_FULL;
    logic        cur_fixed = 1'b0;    // travels with the beat on the input bus
    t_result     cur_want = '0;
    int          n_items = 0;
    int          n_bad = 0;
    int          rx_wait = 0;
    int          quiet = 0;

    hms_countdown_timer_presets_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_advance        (i_advance),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hour_digit     (o_hour_digit),
        .o_minute_tens    (o_minute_tens),
        .o_minute_ones    (o_minute_ones),
        .o_second_tens    (o_second_tens),
        .o_second_ones    (o_second_ones),
        .o_is_running     (o_is_running),
        .o_expired        (o_expired),
        .o_display_update (o_display_update)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command to the shadow state and return the readout it yields.
    task automatic count_down_step(input logic [1:0] cmd, input logic adv,
                                   output t_result r);
        logic [16:0] period;
        logic [16:0] next_cnt;
        logic [2:0]  idx;
        logic        refresh;
        logic        expd;
        refresh = 1'b0;
        expd    = 1'b0;
        case (cmd)
            CMD_TICK: begin
                // Stopped: the prescaler just holds.
                if (pr_counting) begin
                    // A period of zero behaves as one tick per second.
                    period   = (pr_period == 16'd0) ? 17'd1 : {1'b0, pr_period};
                    next_cnt = {1'b0, pr_prescale} + 17'd1;
                    // ">=" so that a period lowered under the count ends the
                    // second on the very next tick.
                    if (next_cnt >= period) begin
                        pr_prescale = '0;
                        refresh = 1'b1;
                        if (pr_secs != 6'd0) begin
                            pr_secs = pr_secs - 6'd1;
                        end else if (pr_mins != 6'd0) begin
                            pr_mins = pr_mins - 6'd1;
                            pr_secs = SECS_MAX;
                        end else if (pr_hours != 4'd0) begin
                            pr_hours = pr_hours - 4'd1;
                            pr_mins  = MINS_MAX;
                            pr_secs  = SECS_MAX;
                        end else begin
                            refresh = 1'b0;  // already at zero: just stop
                        end
                        // Landing on 0:00:00 stops and holds; expiry only
                        // when this very second got us there.
                        if ({pr_hours, pr_mins, pr_secs} == '0) begin
                            pr_counting = 1'b0;
                            expd = refresh;
                        end
                    end else begin
                        pr_prescale = next_cnt[15:0];
                    end
                end
            end
            CMD_SELECT: begin
                idx = pr_idx % PRESET_COUNT;
                if (adv) begin
                    idx = (idx + 3'd1) % PRESET_COUNT;
                end
                pr_idx = idx;
                case (idx)
                    3'd0: begin pr_hours = 4'd2; pr_mins = 6'd30; end
                    3'd1: begin pr_hours = 4'd0; pr_mins = 6'd30; end
                    3'd2: begin pr_hours = 4'd1; pr_mins = 6'd0;  end
                    3'd3: begin pr_hours = 4'd1; pr_mins = 6'd30; end
                    default: begin pr_hours = 4'd2; pr_mins = 6'd0; end
                endcase
                pr_secs     = '0;
                pr_counting = 1'b0;
                pr_prescale = '0;
                refresh     = 1'b1;
            end
            CMD_START: begin
                // No effect at zero time; prescaler keeps its partial count.
                if ({pr_hours, pr_mins, pr_secs} != '0) begin
                    pr_counting = 1'b1;
                end
            end
            default: ;  // unused code: state unchanged
        endcase
        r.hour_digit     = pr_hours;
        r.minute_tens    = 3'(pr_mins / 6'd10);
        r.minute_ones    = 4'(pr_mins % 6'd10);
        r.second_tens    = 3'(pr_secs / 6'd10);
        r.second_ones    = 4'(pr_secs % 6'd10);
        r.is_running     = pr_counting;
        r.expired        = expd;
        r.display_update = refresh;
    endtask

    function automatic t_result readout(input logic [3:0] h, input logic [2:0] mt,
                                        input logic [3:0] mo, input logic [2:0] st,
                                        input logic [3:0] so, input logic run,
                                        input logic ex, input logic upd);
        return {h, mt, mo, st, so, run, ex, upd};
    endfunction

    task automatic add_row(input logic is_cfg, input logic [15:0] period,
                           input logic [1:0] cmd, input logic adv,
                           input logic fixed, input t_result want);
        dir_rows.push_back({is_cfg, period, cmd, adv, fixed, want});
    endtask

    // Wait cycles before the next beat, per the current gap style.
    function automatic int draw_wait();
        case (idle_mode)
            GAPS_NONE: return 0;
            GAPS_FULL: return $urandom_range(0, 18);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    // Present one beat and hold it until accepted. Valid is only dropped
    // when a gap follows, so back-to-back beats keep valid high.
    task automatic send_item(input logic [1:0] cmd, input logic adv,
                             input logic fixed, input t_result want);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            idle_mode = t_gaps'($urandom_range(0, 2));
        end
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_advance  <= adv;
        cur_fixed  <= fixed;
        cur_want   <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
    endtask

    // Stop sending and wait until every queued readout has come back. The
    // outer loop covers a beat accepted on this same edge, not yet queued.
    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            while (due_readouts.size() != 0) @(posedge i_clk);
            repeat (FLUSH_CYCLES) @(posedge i_clk);
        end while (due_readouts.size() != 0);
    endtask

    // Period writes only with the pipe empty.
    task automatic program_period(input logic [15:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pr_period = v;
    endtask

    // Predict on input acceptance, compare on output acceptance.
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                count_down_step(i_command, i_advance, want);
                if (cur_fixed) begin
                    want = cur_want;
                end
                due_readouts.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got = {o_hour_digit, o_minute_tens, o_minute_ones, o_second_tens,
                       o_second_ones, o_is_running, o_expired, o_display_update};
                if (due_readouts.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("unexpected beat at %0t: %0d:%0d%0d:%0d%0d", $time,
                                 got.hour_digit, got.minute_tens, got.minute_ones,
                                 got.second_tens, got.second_ones);
                    end
                end else begin
                    want = due_readouts.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display({"mismatch at %0t: want %0d:%0d%0d:%0d%0d run=%b ",
                                      "exp=%b upd=%b, got %0d:%0d%0d:%0d%0d run=%b ",
                                      "exp=%b upd=%b"}, $time,
                                     want.hour_digit, want.minute_tens, want.minute_ones,
                                     want.second_tens, want.second_ones, want.is_running,
                                     want.expired, want.display_update,
                                     got.hour_digit, got.minute_tens, got.minute_ones,
                                     got.second_tens, got.second_ones, got.is_running,
                                     got.expired, got.display_update);
                        end
                    end
                end
            end
        end
    end

    // Sink: after each taken beat, hold ready low for a drawn number of cycles.
    always @(posedge i_clk) begin : sink
        int w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait     <= 0;
        end else if (o_out_valid && i_out_ready) begin
            w = draw_wait();
            rx_wait     <= w;
            i_out_ready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_ready <= (rx_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [2:0]  k;
        logic        stepped;
        logic [15:0] per;
        logic [1:0]  cmd;
        int          ticks_sent;
        int          phase;
        int          sel;

        // Directed table. Readouts are typed in where they are obvious:
        // out of reset, the preset loads, and the first minute borrow.
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b1, readout(0, 0, 0, 0, 0, 0, 0, 0));
        // start with the time at zero: stays stopped
        add_row(1'b0, 16'd0, CMD_START,  1'b0, 1'b1, readout(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(1'b0, 16'd0, CMD_UNUSED, 1'b1, 1'b1, readout(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(1'b0, 16'd0, CMD_SELECT, 1'b0, 1'b1, readout(2, 3, 0, 0, 0, 0, 0, 1));
        add_row(1'b0, 16'd0, CMD_SELECT, 1'b1, 1'b1, readout(0, 3, 0, 0, 0, 0, 0, 1));
        add_row(1'b0, 16'd0, CMD_SELECT, 1'b1, 1'b1, readout(1, 0, 0, 0, 0, 0, 0, 1));
        add_row(1'b0, 16'd0, CMD_SELECT, 1'b1, 1'b1, readout(1, 3, 0, 0, 0, 0, 0, 1));
        add_row(1'b0, 16'd0, CMD_SELECT, 1'b1, 1'b1, readout(2, 0, 0, 0, 0, 0, 0, 1));
        // index wraps after the last preset
        add_row(1'b0, 16'd0, CMD_SELECT, 1'b1, 1'b1, readout(2, 3, 0, 0, 0, 0, 0, 1));
        add_row(1'b0, 16'd0, CMD_TICK,   1'b1, 1'b0, '0);   // tick while stopped
        add_row(1'b1, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);   // zero period acts as one
        add_row(1'b0, 16'd0, CMD_START,  1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_START,  1'b1, 1'b0, '0);   // start while running
        // 2:30:00 -> 2:29:59, borrow from the minutes
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b1, readout(2, 2, 9, 5, 9, 1, 0, 1));
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_UNUSED, 1'b0, 1'b0, '0);
        add_row(1'b1, 16'hFFFF, CMD_TICK, 1'b0, 1'b0, '0);  // longest period
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_TICK,   1'b1, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);
        // period dropped under the running count: next tick ends the second
        add_row(1'b1, 16'd2, CMD_TICK,   1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_SELECT, 1'b0, 1'b0, '0);
        add_row(1'b0, 16'd0, CMD_TICK,   1'b0, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                program_period(dir_rows[i].period);
            end else begin
                send_item(dir_rows[i].cmd, dir_rows[i].adv, dir_rows[i].fixed,
                          dir_rows[i].want);
            end
        end

        // Random phases, each behind a drained pipe and a new period. Phase
        // two runs the shortest preset all the way down to expiry.
        phase = 0;
        while (n_items < ITEM_TARGET) begin
            if (phase == 2) begin
                program_period(16'($urandom_range(0, 1)));
                // step through the presets until 0:30:00 is loaded
                k = pr_idx % PRESET_COUNT;
                do begin
                    stepped = (k != 3'd1);
                    send_item(CMD_SELECT, stepped, 1'b0, '0);
                    if (stepped) begin
                        k = (k + 3'd1) % PRESET_COUNT;
                    end
                end while (k != 3'd1);
                send_item(CMD_START, 1'($urandom_range(0, 1)), 1'b0, '0);
                // a few ticks past expiry check the hold at zero
                ticks_sent = 0;
                while (ticks_sent < COUNTDOWN_SECS + 3) begin
                    if ($urandom_range(0, 29) == 0) begin
                        cmd = ($urandom_range(0, 1) == 0) ? CMD_START : CMD_UNUSED;
                        send_item(cmd, 1'($urandom_range(0, 1)), 1'b0, '0);
                    end else begin
                        send_item(CMD_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
                        ticks_sent++;
                    end
                end
                send_item(CMD_START, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                case ($urandom_range(0, 9))
                    0:       per = 16'd0;
                    1:       per = 16'hFFFF;
                    2:       per = 16'($urandom_range(0, 65535));
                    3, 4, 5: per = 16'($urandom_range(1, 3));
                    default: per = 16'($urandom_range(1, 12));
                endcase
                program_period(per);
                repeat ($urandom_range(20, 80)) begin
                    sel = $urandom_range(0, 19);
                    if (sel < 12) begin
                        cmd = CMD_TICK;
                    end else if (sel < 15) begin
                        cmd = CMD_SELECT;
                    end else if (sel < 18) begin
                        cmd = CMD_START;
                    end else begin
                        cmd = CMD_UNUSED;
                    end
                    send_item(cmd, 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end
            phase++;
        end

        drain();
        if (n_bad == 0 && due_readouts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/hmsct_pkg.sv
sv/hmsct_digits.sv
sv/hmsct_step.sv
sv/hms_countdown_timer_presets_core.sv
test/hms_countdown_timer_presets_core_tb.sv
